// File: src/hds_pkg.sv
// ----------------------------------------------------------------------------
// hds_pkg: shared types and constants of the heat diffusion stencil step
// Temperature, ratio and grid side types, register indexes, and the issue
// descriptor passed from the sequencer to the update pipeline.
// ----------------------------------------------------------------------------
package hds_pkg;

  // signed Q16.16 temperature
  typedef logic signed [31:0] temp_t;
  // unsigned Q1.16 diffusion ratio
  typedef logic [16:0] ratio_t;
  // grid side as written
  typedef logic [5:0] side_t;

  // N+S+W+E-4T, exact
  typedef logic signed [34:0] lap_t;
  // lap times ratio, exact
  typedef logic signed [52:0] prod_t;

  localparam temp_t TEMP_MIN = {1'b1, {31{1'b0}}};
  localparam temp_t TEMP_MAX = {1'b0, {31{1'b1}}};

  localparam side_t SIDE_MIN   = 6'd3;
  localparam side_t SIDE_RESET = 6'd32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_DIFFUSION_RATIO = 2'd0;
  localparam cfg_idx_t REG_GRID_SIDE       = 2'd1;

  // one issued read of the line store and what to do with it
  typedef struct packed {
    logic valid;     // a result follows from this issue
    logic interior;  // apply the stencil update
    logic t_from_a;  // center value comes from read port A
    logic last;      // final cell of the grid
  } issue_t;

endpackage

// File: src/hds_in_if.sv
// ----------------------------------------------------------------------------
// hds_in_if: input cell channel
// Valid/ready channel carrying one cell temperature per transfer.
// ----------------------------------------------------------------------------
interface hds_in_if;
  logic           valid;
  logic           ready;
  hds_pkg::temp_t cell_temp;

  modport source (output valid, output cell_temp, input ready);
  modport sink   (input valid, input cell_temp, output ready);
endinterface

// File: src/hds_out_if.sv
// ----------------------------------------------------------------------------
// hds_out_if: result cell channel
// Valid/ready channel carrying one updated cell per transfer.
// ----------------------------------------------------------------------------
interface hds_out_if;
  logic           valid;
  logic           ready;
  hds_pkg::temp_t new_temp;
  logic           is_last;
  hds_pkg::temp_t max_temp;

  modport source (output valid, output new_temp, output is_last, output max_temp,
                  input ready);
  modport sink   (input valid, input new_temp, input is_last, input max_temp,
                  output ready);
endinterface

// File: src/hds_line_store.sv
// ----------------------------------------------------------------------------
// hds_line_store: two-row line store
// One write port and two registered read ports. A read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module hds_line_store #(
  parameter int GRID_MAX = 32,
  parameter int AW       = $clog2(2 * GRID_MAX)
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  hds_pkg::temp_t wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr_a,
  input  logic [AW-1:0]  rd_addr_b,
  output hds_pkg::temp_t rd_data_a,
  output hds_pkg::temp_t rd_data_b
);
  import hds_pkg::*;

  localparam int DEPTH = 2 * GRID_MAX;

  temp_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, data held between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// File: src/hds_update.sv
// ----------------------------------------------------------------------------
// hds_update: stencil update pipeline
// Builds the five-point window from the line store reads, forms the
// Laplacian, scales it by the ratio, saturates, tracks the interior maximum
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module hds_update (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  hds_pkg::issue_t     iss,
  input  hds_pkg::temp_t      iss_x,
  input  hds_pkg::temp_t      rd_a,
  input  hds_pkg::temp_t      rd_b,
  input  hds_pkg::ratio_t     ratio,
  input  logic                clear_max,
  output logic                o_valid,
  output hds_pkg::temp_t      o_temp,
  output logic                o_last,
  output hds_pkg::temp_t      o_max
);
  import hds_pkg::*;

  typedef logic signed [37:0] sum_t;
  typedef logic signed [36:0] delta_t;

  localparam sum_t SUM_HI = sum_t'(TEMP_MAX);
  localparam sum_t SUM_LO = sum_t'(TEMP_MIN);

  // stage 1: descriptor aligned with read data
  issue_t s1_iss;
  temp_t  s1_x;
  // window: previous center and previous east of the row above
  temp_t  win_t;
  temp_t  win_e;
  // stage 2
  logic   s2_valid, s2_interior, s2_last;
  temp_t  s2_t;
  lap_t   s2_lap;
  // stage 3
  logic   s3_valid, s3_interior, s3_last;
  temp_t  s3_t;
  prod_t  s3_prod;
  // interior maximum of the grid so far
  temp_t  run_max;

  temp_t  t_sel;
  lap_t   lap;
  prod_t  prod;
  logic signed [17:0] ratio_s;
  delta_t delta;
  sum_t   sum;
  temp_t  sat;
  temp_t  val;
  temp_t  max_cand;

  // window and Laplacian
  always_comb begin
    t_sel = s1_iss.t_from_a ? rd_a : win_e;
    lap   = lap_t'(rd_a) + lap_t'(s1_x) + lap_t'(win_t) + lap_t'(rd_b)
          - (lap_t'(t_sel) <<< 2);
  end

  // scale by ratio
  assign ratio_s = $signed({1'b0, ratio});
  assign prod    = s2_lap * ratio_s;

  // floor to Q16.16, add, saturate, maximum
  always_comb begin
    delta = s3_prod[52:16];
    sum   = sum_t'(s3_t) + sum_t'(delta);
    if (sum > SUM_HI) begin
      sat = TEMP_MAX;
    end else if (sum < SUM_LO) begin
      sat = TEMP_MIN;
    end else begin
      sat = sum[31:0];
    end
    val      = s3_interior ? sat : s3_t;
    max_cand = (s3_interior && (sat > run_max)) ? sat : run_max;
  end

  // control and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_iss   <= '0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      o_valid  <= 1'b0;
      run_max  <= TEMP_MIN;
    end else begin
      if (adv) begin
        s1_iss   <= iss;
        s2_valid <= s1_iss.valid;
        s3_valid <= s2_valid;
        o_valid  <= s3_valid;
      end
      // a grid restart wins over the running update
      if (clear_max) begin
        run_max <= TEMP_MIN;
      end else if (adv && s3_valid) begin
        run_max <= s3_last ? TEMP_MIN : max_cand;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x        <= iss_x;
      if (s1_iss.valid) begin
        win_t <= t_sel;
        win_e <= rd_b;
      end
      s2_interior <= s1_iss.interior;
      s2_last     <= s1_iss.last;
      s2_t        <= t_sel;
      s2_lap      <= lap;
      s3_interior <= s2_interior;
      s3_last     <= s2_last;
      s3_t        <= s2_t;
      s3_prod     <= prod;
      o_temp      <= val;
      o_last      <= s3_last;
      o_max       <= s3_last ? max_cand : '0;
    end
  end

endmodule

// File: src/heat_diffusion_stencil_step.sv
// ----------------------------------------------------------------------------
// heat_diffusion_stencil_step: one explicit heat diffusion step on a grid
// Raster-order cell stream in, updated cells out one row behind.
// ----------------------------------------------------------------------------
// While the result channel does not stall it, the block takes one cell per
// cycle, except while it drains, and gives one result per cycle. Results for
// row k leave while row k+1 streams in; row 0 produces none. After the final
// cell of a grid the block drains the final row (n cells, n = grid side in
// use) from the line store through its one read port pair, taking no input.
// A result's cell passes line store read, Laplacian, multiply, and saturate
// into the output register. The line store needs no clearing pass.
// Writing grid_side restarts the grid; write configuration only when idle.
module heat_diffusion_stencil_step #(
  parameter int GRID_MAX = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  hds_pkg::cfg_idx_t cfg_index,
  input  hds_pkg::cfg_data_t cfg_data,
  hds_in_if.sink            cells,
  hds_out_if.source         results
);
  import hds_pkg::*;

  localparam int CW = $clog2(GRID_MAX);
  localparam int AW = $clog2(2 * GRID_MAX);

  typedef logic [CW-1:0] col_t;
  typedef logic [AW-1:0] addr_t;

  typedef enum logic [1:0] {
    ST_STREAM = 2'b01,
    ST_FLUSH  = 2'b10
  } state_t;

  state_t  state;
  ratio_t  ratio;
  side_t   grid_side;
  col_t    row, col;
  col_t    fcc;
  logic    fhalf;

  side_t   n, n_m1;
  logic    adv, accept, final_cell, side_wr, rd_en;
  issue_t  iss;
  addr_t   addr_a, addr_b, addr_w;
  col_t    east_col;
  logic    o_valid, o_last;
  temp_t   o_temp, o_max;
  temp_t   rd_a, rd_b;

  function automatic addr_t loc(input logic half, input col_t c);
    return half ? addr_t'(GRID_MAX) + addr_t'(c) : addr_t'(c);
  endfunction

  // side in use
  always_comb begin
    if (grid_side < SIDE_MIN) begin
      n = SIDE_MIN;
    end else if (grid_side > side_t'(GRID_MAX)) begin
      n = side_t'(GRID_MAX);
    end else begin
      n = grid_side;
    end
    n_m1 = n - 6'd1;
  end

  // pipeline moves whenever the output register is free or drains
  assign adv           = !o_valid || results.ready;
  assign cells.ready   = adv && (state == ST_STREAM);
  assign accept        = cells.valid && cells.ready;
  assign final_cell    = (side_t'(row) == n_m1) && (side_t'(col) == n_m1);
  assign side_wr       = cfg_we && (cfg_index == REG_GRID_SIDE);

  // read issue and addressing
  always_comb begin
    east_col = (side_t'(col) == n_m1) ? col : col + col_t'(1);
    addr_w   = loc(row[0], col);
    addr_b   = loc(~row[0], east_col);
    iss      = '0;
    if (state == ST_FLUSH) begin
      iss.valid    = 1'b1;
      iss.t_from_a = 1'b1;
      iss.last     = (side_t'(fcc) == n_m1);
      addr_a       = loc(fhalf, fcc);
      rd_en        = adv;
    end else begin
      iss.valid    = accept && (row != '0);
      iss.interior = (side_t'(row) >= 6'd2) && (col != '0) && (side_t'(col) < n_m1);
      iss.t_from_a = (col == '0);
      addr_a       = (col == '0) ? loc(~row[0], '0) : loc(row[0], col);
      rd_en        = accept;
    end
  end

  // configuration, position counters and flush sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      ratio     <= '0;
      grid_side <= SIDE_RESET;
      row       <= '0;
      col       <= '0;
      fcc       <= '0;
      fhalf     <= 1'b0;
      state     <= ST_STREAM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFFUSION_RATIO: ratio <= cfg_data;
        REG_GRID_SIDE: begin
          grid_side <= cfg_data[5:0];
          row       <= '0;
          col       <= '0;
        end
        default: ;
      endcase
    end else begin
      case (state)
        ST_STREAM: begin
          if (accept) begin
            if (final_cell) begin
              fhalf <= row[0];
              fcc   <= '0;
              row   <= '0;
              col   <= '0;
              state <= ST_FLUSH;
            end else if (side_t'(col) == n_m1) begin
              col <= '0;
              row <= row + col_t'(1);
            end else begin
              col <= col + col_t'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (adv) begin
            fcc <= fcc + col_t'(1);
            if (side_t'(fcc) == n_m1) begin
              state <= ST_STREAM;
            end
          end
        end
        default: state <= ST_STREAM;
      endcase
    end
  end

  hds_line_store #(
    .GRID_MAX (GRID_MAX),
    .AW       (AW)
  ) u_line_store (
    .clk       (clk),
    .wr_en     (accept),
    .wr_addr   (addr_w),
    .wr_data   (cells.cell_temp),
    .rd_en     (rd_en),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  hds_update u_update (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .iss       (iss),
    .iss_x     (cells.cell_temp),
    .rd_a      (rd_a),
    .rd_b      (rd_b),
    .ratio     (ratio),
    .clear_max (side_wr),
    .o_valid   (o_valid),
    .o_temp    (o_temp),
    .o_last    (o_last),
    .o_max     (o_max)
  );

  // result channel
  assign results.valid    = o_valid;
  assign results.new_temp = o_temp;
  assign results.is_last  = o_last;
  assign results.max_temp = o_max;

endmodule

// File: src/hds_checker.sv
// ----------------------------------------------------------------------------
// hds_checker: port-level checks of the stencil step
// Watches the cell and result channels of the top level over time.
// ----------------------------------------------------------------------------
module hds_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input hds_pkg::temp_t new_temp,
  input logic           is_last,
  input hds_pkg::temp_t max_temp
);
  import hds_pkg::*;

  // no result straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds off new cells
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("cell transfer possible while result stalled");

  // max field only on the final cell
  a_max_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> max_temp == '0)
    else $error("max_temp nonzero on a non-final result");

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(new_temp))
    else $error("stalled result changed");

endmodule

bind heat_diffusion_stencil_step hds_checker u_hds_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cells.valid),
  .in_ready  (cells.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .new_temp  (results.new_temp),
  .is_last   (results.is_last),
  .max_temp  (results.max_temp)
);
